FILE: hw/rtl/segment_rectangle_intersect_top_assert.svh
// Assertion macros shared by the checker of the segment/rectangle intersect block.
// Needs no other file; take it in by `include.
`ifndef SEGMENT_RECTANGLE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_RECTANGLE_INTERSECT_TOP_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is high.
`define SRI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication checked in the cycle after the antecedent, masked while reset is high.
`define SRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Implication that also holds through reset.
`define SRI_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("reset-time check failed");

`endif

FILE: hw/rtl/srect_pkg.sv
// Shared widths, types and index constants for the segment/rectangle intersect block.
// Depends on nothing; every RTL module takes names from here by scope.
`default_nettype none

package srect_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned DIFF_BITS     = COORD_BITS + 1;
  localparam int unsigned PROD_BITS     = 2 * DIFF_BITS;
  localparam int unsigned CROSS_BITS    = PROD_BITS + 1;
  localparam int unsigned NUM_FIELDS    = 8;
  localparam int unsigned IN_DATA_BITS  = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = 8;

  // Slot of each input field in tdata, lowest first.
  localparam int unsigned F_SX = 0;
  localparam int unsigned F_SY = 1;
  localparam int unsigned F_EX = 2;
  localparam int unsigned F_EY = 3;
  localparam int unsigned F_AX = 4;
  localparam int unsigned F_AY = 5;
  localparam int unsigned F_BX = 6;
  localparam int unsigned F_BY = 7;

  // Corners in edge order; edge k runs from corner k to corner k+1.
  localparam int unsigned CRN_TL = 0;
  localparam int unsigned CRN_TR = 1;
  localparam int unsigned CRN_BR = 2;
  localparam int unsigned CRN_BL = 3;
  localparam int unsigned EDG_TOP = 0;
  localparam int unsigned EDG_RGT = 1;
  localparam int unsigned EDG_BOT = 2;
  localparam int unsigned EDG_LFT = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    coord_t s_x;
    coord_t s_y;
    coord_t e_x;
    coord_t e_y;
    coord_t lft;
    coord_t rgt;
    coord_t top;
    coord_t bot;
    diff_t  dx;      // end minus start, x
    diff_t  dy;      // end minus start, y
    diff_t  d_top;   // top minus start y
    diff_t  d_bot;   // bottom minus start y
    diff_t  d_lft;   // left minus start x
    diff_t  d_rgt;   // right minus start x
  } prep_t;

  typedef struct packed {
    logic       end_hit;   // endpoint on an edge, or both endpoints inside
    logic [3:0] straddle;  // endpoints strictly on both sides of each edge line
    logic [3:0] bbox;      // corner within the segment's bounding box
  } flags_t;

  typedef struct packed {
    prod_t  m_xt;   // dx * d_top
    prod_t  m_xb;   // dx * d_bot
    prod_t  m_yl;   // dy * d_lft
    prod_t  m_yr;   // dy * d_rgt
    flags_t flags;
  } prod_stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srect_prep.sv
// First stage: unpack the request, order the rectangle corners, form differences.
// Depends on srect_pkg.
`default_nettype none

module srect_prep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [srect_pkg::IN_DATA_BITS-1:0]   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output srect_pkg::prep_t                     out_prep
);

  srect_pkg::coord_t sx, sy, ex, ey, ax, ay, bx, by;
  srect_pkg::prep_t  prep_next;

  assign sx = in_data[srect_pkg::F_SX*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign sy = in_data[srect_pkg::F_SY*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign ex = in_data[srect_pkg::F_EX*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign ey = in_data[srect_pkg::F_EY*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign ax = in_data[srect_pkg::F_AX*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign ay = in_data[srect_pkg::F_AY*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign bx = in_data[srect_pkg::F_BX*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];
  assign by = in_data[srect_pkg::F_BY*srect_pkg::COORD_BITS +: srect_pkg::COORD_BITS];

  always_comb begin
    prep_next.s_x   = sx;
    prep_next.s_y   = sy;
    prep_next.e_x   = ex;
    prep_next.e_y   = ey;
    prep_next.lft   = (ax < bx) ? ax : bx;
    prep_next.rgt   = (ax < bx) ? bx : ax;
    prep_next.top   = (ay > by) ? ay : by;
    prep_next.bot   = (ay > by) ? by : ay;
    prep_next.dx    = srect_pkg::diff_t'(ex) - srect_pkg::diff_t'(sx);
    prep_next.dy    = srect_pkg::diff_t'(ey) - srect_pkg::diff_t'(sy);
    prep_next.d_top = srect_pkg::diff_t'(prep_next.top) - srect_pkg::diff_t'(sy);
    prep_next.d_bot = srect_pkg::diff_t'(prep_next.bot) - srect_pkg::diff_t'(sy);
    prep_next.d_lft = srect_pkg::diff_t'(prep_next.lft) - srect_pkg::diff_t'(sx);
    prep_next.d_rgt = srect_pkg::diff_t'(prep_next.rgt) - srect_pkg::diff_t'(sx);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prep <= prep_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srect_prod.sv
// Second stage: the four cross-product terms and all compare-only tests.
// Depends on srect_pkg.
`default_nettype none

module srect_prod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  srect_pkg::prep_t          in_prep,
  output logic                      out_valid,
  input  logic                      out_ready,
  output srect_pkg::prod_stage_t    out_prod
);

  srect_pkg::prod_stage_t prod_next;
  logic s_on, e_on, s_in, e_in;
  logic xl_in, xr_in, yt_in, yb_in;

  always_comb begin
    // Point on an axis-aligned edge reduces to one equality and a range check.
    s_on = ((in_prep.lft <= in_prep.s_x) && (in_prep.s_x <= in_prep.rgt) &&
            ((in_prep.s_y == in_prep.top) || (in_prep.s_y == in_prep.bot))) ||
           ((in_prep.bot <= in_prep.s_y) && (in_prep.s_y <= in_prep.top) &&
            ((in_prep.s_x == in_prep.lft) || (in_prep.s_x == in_prep.rgt)));
    e_on = ((in_prep.lft <= in_prep.e_x) && (in_prep.e_x <= in_prep.rgt) &&
            ((in_prep.e_y == in_prep.top) || (in_prep.e_y == in_prep.bot))) ||
           ((in_prep.bot <= in_prep.e_y) && (in_prep.e_y <= in_prep.top) &&
            ((in_prep.e_x == in_prep.lft) || (in_prep.e_x == in_prep.rgt)));
    s_in = (in_prep.lft < in_prep.s_x) && (in_prep.s_x < in_prep.rgt) &&
           (in_prep.bot < in_prep.s_y) && (in_prep.s_y < in_prep.top);
    e_in = (in_prep.lft < in_prep.e_x) && (in_prep.e_x < in_prep.rgt) &&
           (in_prep.bot < in_prep.e_y) && (in_prep.e_y < in_prep.top);

    // Corner coordinates within the segment's x and y spans.
    xl_in = ((in_prep.s_x <= in_prep.lft) && (in_prep.lft <= in_prep.e_x)) ||
            ((in_prep.e_x <= in_prep.lft) && (in_prep.lft <= in_prep.s_x));
    xr_in = ((in_prep.s_x <= in_prep.rgt) && (in_prep.rgt <= in_prep.e_x)) ||
            ((in_prep.e_x <= in_prep.rgt) && (in_prep.rgt <= in_prep.s_x));
    yt_in = ((in_prep.s_y <= in_prep.top) && (in_prep.top <= in_prep.e_y)) ||
            ((in_prep.e_y <= in_prep.top) && (in_prep.top <= in_prep.s_y));
    yb_in = ((in_prep.s_y <= in_prep.bot) && (in_prep.bot <= in_prep.e_y)) ||
            ((in_prep.e_y <= in_prep.bot) && (in_prep.bot <= in_prep.s_y));

    prod_next.flags.end_hit = s_on || e_on || (s_in && e_in);

    prod_next.flags.bbox[srect_pkg::CRN_TL] = xl_in && yt_in;
    prod_next.flags.bbox[srect_pkg::CRN_TR] = xr_in && yt_in;
    prod_next.flags.bbox[srect_pkg::CRN_BR] = xr_in && yb_in;
    prod_next.flags.bbox[srect_pkg::CRN_BL] = xl_in && yb_in;

    prod_next.flags.straddle[srect_pkg::EDG_TOP] =
      ((in_prep.s_y < in_prep.top) && (in_prep.top < in_prep.e_y)) ||
      ((in_prep.e_y < in_prep.top) && (in_prep.top < in_prep.s_y));
    prod_next.flags.straddle[srect_pkg::EDG_BOT] =
      ((in_prep.s_y < in_prep.bot) && (in_prep.bot < in_prep.e_y)) ||
      ((in_prep.e_y < in_prep.bot) && (in_prep.bot < in_prep.s_y));
    prod_next.flags.straddle[srect_pkg::EDG_RGT] =
      ((in_prep.s_x < in_prep.rgt) && (in_prep.rgt < in_prep.e_x)) ||
      ((in_prep.e_x < in_prep.rgt) && (in_prep.rgt < in_prep.s_x));
    prod_next.flags.straddle[srect_pkg::EDG_LFT] =
      ((in_prep.s_x < in_prep.lft) && (in_prep.lft < in_prep.e_x)) ||
      ((in_prep.e_x < in_prep.lft) && (in_prep.lft < in_prep.s_x));

    prod_next.m_xt = srect_pkg::prod_t'(in_prep.dx) * srect_pkg::prod_t'(in_prep.d_top);
    prod_next.m_xb = srect_pkg::prod_t'(in_prep.dx) * srect_pkg::prod_t'(in_prep.d_bot);
    prod_next.m_yl = srect_pkg::prod_t'(in_prep.dy) * srect_pkg::prod_t'(in_prep.d_lft);
    prod_next.m_yr = srect_pkg::prod_t'(in_prep.dy) * srect_pkg::prod_t'(in_prep.d_rgt);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srect_decide.sv
// Third and fourth stages: corner cross signs, then the final hit decision.
// Depends on srect_pkg; the last register here drives the output stream.
`default_nettype none

module srect_decide (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  srect_pkg::prod_stage_t    in_prod,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit
);

  srect_pkg::cross_t cr [4];
  logic [3:0]        pos_next, neg_next;

  // Sign stage registers
  logic              sgn_valid;
  logic              sgn_ready;
  logic [3:0]        pos, neg;
  srect_pkg::flags_t flags;

  logic [3:0] corner_hit;
  logic [3:0] edge_cross;
  logic       hit_next;

  // Cross of the segment direction with each corner relative to the start point.
  always_comb begin
    cr[srect_pkg::CRN_TL] = srect_pkg::cross_t'(in_prod.m_xt) -
                            srect_pkg::cross_t'(in_prod.m_yl);
    cr[srect_pkg::CRN_TR] = srect_pkg::cross_t'(in_prod.m_xt) -
                            srect_pkg::cross_t'(in_prod.m_yr);
    cr[srect_pkg::CRN_BR] = srect_pkg::cross_t'(in_prod.m_xb) -
                            srect_pkg::cross_t'(in_prod.m_yr);
    cr[srect_pkg::CRN_BL] = srect_pkg::cross_t'(in_prod.m_xb) -
                            srect_pkg::cross_t'(in_prod.m_yl);
    for (int i = 0; i < 4; i++) begin
      neg_next[i] = cr[i][srect_pkg::CROSS_BITS-1];
      pos_next[i] = !cr[i][srect_pkg::CROSS_BITS-1] && (cr[i] != '0);
    end
  end

  assign in_ready  = !sgn_valid || sgn_ready;
  assign sgn_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sgn_valid <= 1'b0;
    end else if (in_ready) begin
      sgn_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pos   <= pos_next;
      neg   <= neg_next;
      flags <= in_prod.flags;
    end
  end

  // Edge k joins corner k and corner k+1; a proper crossing needs opposite strict signs.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      corner_hit[i] = !pos[i] && !neg[i] && flags.bbox[i];
      edge_cross[i] = flags.straddle[i] &&
                      ((pos[i] && neg[(i + 1) % 4]) || (neg[i] && pos[(i + 1) % 4]));
    end
    hit_next = flags.end_hit || (|corner_hit) || (|edge_cross);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sgn_ready) begin
      out_valid <= sgn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sgn_ready && sgn_valid) begin
      hit <= hit_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/segment_rectangle_intersect_top.sv
// Segment vs axis-aligned rectangle: four register stages, one request per cycle if unstalled.
// An accepted request passes the prep, product, sign and hit registers before output valid.
// Throughput: one request per cycle; a stalled output backs up stage by stage, losing nothing.
// Stage split: corner ordering, 17x17 multiplies, cross signs, hit decision.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
// Depends on srect_pkg, srect_prep, srect_prod and srect_decide.
`default_nettype none

module segment_rectangle_intersect_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y (16 bits each)
  input  logic [srect_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // hit (bit 0), zero padding above
  output logic [srect_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  logic                   prep_valid, prep_ready;
  srect_pkg::prep_t       prep;
  logic                   prod_valid, prod_ready;
  srect_pkg::prod_stage_t prod;
  logic                   hit;

  srect_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_prep  (prep)
  );

  srect_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_prep   (prep),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  srect_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hit       (hit)
  );

  assign m_tdata = (srect_pkg::OUT_DATA_BITS)'(hit);

endmodule

`default_nettype wire

FILE: hw/rtl/srect_checker.sv
// Port-level checks for segment_rectangle_intersect_top, attached by bind.
// Depends on srect_pkg and segment_rectangle_intersect_top_assert.svh.
`default_nettype none
`include "segment_rectangle_intersect_top_assert.svh"

module srect_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [srect_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [srect_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  // Output held while stalled.
  `SRI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Only the hit bit may be set.
  `SRI_ASSERT_IMPLY(a_out_pad, clk, rst, m_tvalid, m_tdata[srect_pkg::OUT_DATA_BITS-1:1] == '0)
  // An empty output register lets the whole pipeline advance.
  `SRI_ASSERT_IMPLY(a_ready_free, clk, rst, !m_tvalid, s_tready)
  // An offered request carries known data.
  `SRI_ASSERT_IMPLY(a_in_known, clk, rst, s_tvalid, !$isunknown(s_tdata))
  // Nothing comes out right after reset.
  `SRI_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !m_tvalid)

endmodule

bind segment_rectangle_intersect_top srect_checker u_srect_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/tb_segment_rectangle_intersect_top.sv
// Testbench for segment_rectangle_intersect_top: streams segment/rectangle queries, predicts
// each hit bit with an independent integer geometry model and checks results in order.
// Depends on srect_pkg and the RTL of segment_rectangle_intersect_top.
`timescale 1ns / 100ps

module tb_segment_rectangle_intersect_top;

  // Last member lands in the lowest bits, so seg_start_x is field 0 of tdata.
  typedef struct packed {
    srect_pkg::coord_t corner_b_y;
    srect_pkg::coord_t corner_b_x;
    srect_pkg::coord_t corner_a_y;
    srect_pkg::coord_t corner_a_x;
    srect_pkg::coord_t seg_end_y;
    srect_pkg::coord_t seg_end_x;
    srect_pkg::coord_t seg_start_y;
    srect_pkg::coord_t seg_start_x;
  } query_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    query_t req;
    bit     hit;
  } hit_entry_t;

  typedef enum int {SPAN_FULL, SPAN_TINY, SPAN_EXTREME, SPAN_MID} span_t;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [srect_pkg::IN_DATA_BITS-1:0]  s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [srect_pkg::OUT_DATA_BITS-1:0] m_tdata;

  hit_entry_t hit_expected_q[$];
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left     = 0;

  segment_rectangle_intersect_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint cross_at(point_t o, point_t a, point_t b);
    return (a.x - o.x) * (b.y - o.y) - (a.y - o.y) * (b.x - o.x);
  endfunction

  function automatic bit point_on_seg(point_t p, point_t s, point_t e);
    longint cr;
    longint dt;
    cr = (s.x - p.x) * (e.y - p.y) - (s.y - p.y) * (e.x - p.x);
    dt = (s.x - p.x) * (e.x - p.x) + (s.y - p.y) * (e.y - p.y);
    return (cr == 0) && (dt <= 0);
  endfunction

  function automatic bit opposite_signs(longint u, longint v);
    return (u > 0 && v < 0) || (u < 0 && v > 0);
  endfunction

  function automatic bit crosses_properly(point_t a0, point_t a1, point_t b0, point_t b1);
    return opposite_signs(cross_at(a0, a1, b1), cross_at(a0, a1, b0)) &&
           opposite_signs(cross_at(b0, b1, a0), cross_at(b0, b1, a1));
  endfunction

  function automatic bit predict_hit(query_t q);
    point_t s, e, p, nq;
    point_t crn[4];
    longint ax, ay, bx, by;
    longint lft, rgt, top, bot;
    bit     hit;
    s.x = q.seg_start_x;
    s.y = q.seg_start_y;
    e.x = q.seg_end_x;
    e.y = q.seg_end_y;
    ax  = q.corner_a_x;
    ay  = q.corner_a_y;
    bx  = q.corner_b_x;
    by  = q.corner_b_y;
    lft = (ax < bx) ? ax : bx;
    rgt = (ax < bx) ? bx : ax;
    top = (ay > by) ? ay : by;
    bot = (ay > by) ? by : ay;
    crn[srect_pkg::CRN_TL] = '{x: lft, y: top};
    crn[srect_pkg::CRN_TR] = '{x: rgt, y: top};
    crn[srect_pkg::CRN_BR] = '{x: rgt, y: bot};
    crn[srect_pkg::CRN_BL] = '{x: lft, y: bot};
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      p  = crn[i];
      nq = crn[(i + 1) % 4];
      if (point_on_seg(s, p, nq) || point_on_seg(e, p, nq)) hit = 1'b1;
      if (point_on_seg(p, s, e)) hit = 1'b1;
      if (crosses_properly(s, e, p, nq)) hit = 1'b1;
    end
    if (lft < s.x && s.x < rgt && bot < s.y && s.y < top &&
        lft < e.x && e.x < rgt && bot < e.y && e.y < top) hit = 1'b1;
    return hit;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic query_t make_query(int sx, int sy, int ex, int ey,
                                        int ax, int ay, int bx, int by);
    query_t q;
    q.seg_start_x = srect_pkg::coord_t'(sx);
    q.seg_start_y = srect_pkg::coord_t'(sy);
    q.seg_end_x   = srect_pkg::coord_t'(ex);
    q.seg_end_y   = srect_pkg::coord_t'(ey);
    q.corner_a_x  = srect_pkg::coord_t'(ax);
    q.corner_a_y  = srect_pkg::coord_t'(ay);
    q.corner_b_x  = srect_pkg::coord_t'(bx);
    q.corner_b_y  = srect_pkg::coord_t'(by);
    return q;
  endfunction

  function automatic srect_pkg::coord_t fresh_coord(span_t span);
    case (span)
      SPAN_FULL: return srect_pkg::coord_t'($urandom);
      SPAN_TINY: return srect_pkg::coord_t'(int'($urandom_range(16)) - 8);
      SPAN_EXTREME: begin
        case ($urandom_range(5))
          0: return srect_pkg::coord_t'(-32768);
          1: return srect_pkg::coord_t'(-32767);
          2: return srect_pkg::coord_t'(-1);
          3: return srect_pkg::coord_t'(0);
          4: return srect_pkg::coord_t'(1);
          default: return srect_pkg::coord_t'(32767);
        endcase
      end
      default: return srect_pkg::coord_t'(int'($urandom_range(400)) - 200);
    endcase
  endfunction

  // Pull segment coordinates onto the rectangle's lines often, so touching and
  // collinear cases come up far more than uniform values would give.
  function automatic srect_pkg::coord_t seg_coord(span_t span, srect_pkg::coord_t c0,
                                                  srect_pkg::coord_t c1);
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return c0;
    if (pick < 30) return c1;
    return fresh_coord(span);
  endfunction

  function automatic query_t random_query();
    query_t q;
    span_t  span;
    span = span_t'($urandom_range(3));
    q.corner_a_x = fresh_coord(span);
    q.corner_a_y = fresh_coord(span);
    q.corner_b_x = ($urandom_range(19) == 0) ? q.corner_a_x : fresh_coord(span);
    q.corner_b_y = ($urandom_range(19) == 0) ? q.corner_a_y : fresh_coord(span);
    q.seg_start_x = seg_coord(span, q.corner_a_x, q.corner_b_x);
    q.seg_start_y = seg_coord(span, q.corner_a_y, q.corner_b_y);
    if ($urandom_range(19) == 0) begin
      q.seg_end_x = q.seg_start_x;
      q.seg_end_y = q.seg_start_y;
    end else begin
      q.seg_end_x = seg_coord(span, q.corner_a_x, q.corner_b_x);
      q.seg_end_y = seg_coord(span, q.corner_a_y, q.corner_b_y);
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= q;
    do @(posedge clk); while (!s_tready);
    hit_expected_q.push_back('{req: q, hit: predict_hit(q)});
  endtask

  // Drop the request and hold until every outstanding hit has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (hit_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    hit_entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (hit_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit=%0b", $time, m_tdata[0]);
        mismatches++;
      end else begin
        want = hit_expected_q.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b (request %h)",
                   $time, want.hit, m_tdata[0], want.req);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_corner_cases();
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1));
    send_query(make_query(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_query(make_query(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_query(make_query(-32767, -32767, 32766, 32766, -32768, -32768, 32767, 32767));
    send_query(make_query(32767, 32767, 32767, 32767, -32768, -32768, 32766, 32766));
    send_query(make_query(-10, 0, 10, 0, -5, -5, 5, 5));
    send_query(make_query(-1, -1, 1, 1, -5, -5, 5, 5));
    send_query(make_query(10, 10, 20, 20, -5, -5, 5, 5));
    send_query(make_query(5, 0, 10, 0, -5, -5, 5, 5));
    send_query(make_query(-10, 5, 10, 5, -5, -5, 5, 5));
    send_query(make_query(0, 5, 0, 20, -5, -5, 5, 5));
    send_query(make_query(4, 6, 6, 4, -5, -5, 5, 5));
    send_query(make_query(11, 0, 0, 11, -5, -5, 5, 5));
    send_query(make_query(-3, 0, 3, 0, 5, -5, -5, 5));
    // degenerate segment: inside, outside, on a corner, on an edge
    send_query(make_query(1, 1, 1, 1, -5, -5, 5, 5));
    send_query(make_query(9, 9, 9, 9, -5, -5, 5, 5));
    send_query(make_query(5, 5, 5, 5, -5, -5, 5, 5));
    send_query(make_query(5, 2, 5, 2, 5, 5, -5, -5));
    // degenerate rectangle: zero width, zero height, a single point
    send_query(make_query(-3, 0, 3, 0, 0, -5, 0, 5));
    send_query(make_query(-3, 1, 3, 1, -5, 0, 5, 0));
    send_query(make_query(0, 0, 6, 6, 3, 3, 3, 3));
    send_query(make_query(0, 1, 6, 7, 3, 3, 3, 3));
    send_query(make_query(2, 2, 2, 2, 2, 2, 2, 2));
    wait_for_drain();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_query(random_query());
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 420);
    run_random_phase(58, 0, 420);
    run_random_phase(0, 58, 420);
    run_random_phase(38, 38, 420);
    wait_for_drain();
  endtask

  // Hold the receiver off long enough that the pipeline fills and s_tready drops.
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    repeat (120) send_query(random_query());
    wait_for_drain();
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (25) send_query(random_query());
    wait_for_drain();
    repeat (25) send_query(random_query());
    wait_for_drain();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_random_traffic();
    test_backpressure_fill();
    test_pause_until_drained();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: segment_rectangle_intersect_top.f
+incdir+hw/rtl
hw/rtl/srect_pkg.sv
hw/rtl/srect_prep.sv
hw/rtl/srect_prod.sv
hw/rtl/srect_decide.sv
hw/rtl/segment_rectangle_intersect_top.sv
hw/rtl/srect_checker.sv
verif/tb_segment_rectangle_intersect_top.sv
